/* design/tarb_pkg.sv */
// ----------------------------------------------------------------------------
// tarb_pkg
// Shared types, constants and word functions of the table add-rotate cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package tarb_pkg;

    localparam int KEY_WORDS   = 36;
    localparam int KEY_GROUPS  = 9;
    localparam int TABLE_DEPTH = 2048;
    localparam int Q_DEPTH     = 2;

    localparam logic [3:0] KEY_LAST = 4'd8;

    // Request codes on the input channel
    localparam logic [2:0] REQ_KEY = 3'd0;
    localparam logic [2:0] REQ_FWD = 3'd1;
    localparam logic [2:0] REQ_INV = 3'd2;
    localparam logic [2:0] REQ_ENC = 3'd3;
    localparam logic [2:0] REQ_DEC = 3'd4;

    typedef enum logic [2:0] {
        K_KEY = 3'd0,
        K_FWD = 3'd1,
        K_INV = 3'd2,
        K_ENC = 3'd3,
        K_DEC = 3'd4
    } t_kind;

    typedef logic [3:0][63:0] t_block;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  key_index;
        logic [2:0]  table_number;
        logic [7:0]  entry_index;
        logic [63:0] load_value;
        t_block      words;
    } t_item;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic t_block mix_fwd(input t_block w);
        t_block m;
        m    = w;
        m[0] = w[0] ^ rotl64(w[1], 11) ^ rotl64(w[2], 27) ^ rotl64(w[3], 43);
        m[1] = w[1] ^ rotl64(m[0], 24);
        m[2] = w[2] ^ rotl64(m[0], 18);
        m[3] = w[3] ^ rotl64(m[0], 10);
        return m;
    endfunction

    function automatic t_block mix_inv(input t_block w);
        t_block m;
        m    = w;
        m[1] = w[1] ^ rotl64(w[0], 24);
        m[2] = w[2] ^ rotl64(w[0], 18);
        m[3] = w[3] ^ rotl64(w[0], 10);
        m[0] = w[0] ^ rotl64(m[1], 11) ^ rotl64(m[2], 27) ^ rotl64(m[3], 43);
        return m;
    endfunction

endpackage

`default_nettype wire

/* design/tarb_front.sv */
// ----------------------------------------------------------------------------
// tarb_front
// Request decode and a short in-order queue feeding the cipher engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tarb_front #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic [2:0]     i_req_type,
    input  wire logic [5:0]     i_key_index,
    input  wire logic [2:0]     i_table_number,
    input  wire logic [7:0]     i_entry_index,
    input  wire logic [63:0]    i_load_value,
    input  wire tarb_pkg::t_block i_words,
    output logic                o_item_valid,
    output tarb_pkg::t_item     o_item,
    input  wire logic           i_item_ready
);
    import tarb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_q [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    t_item          cls;
    logic           keep, push, pop;

    // classify the beat; drop unknown codes and out-of-range key loads
    always_comb begin
        cls.key_index    = i_key_index;
        cls.table_number = i_table_number;
        cls.entry_index  = i_entry_index;
        cls.load_value   = i_load_value;
        cls.words        = i_words;
        cls.kind         = K_KEY;
        keep             = 1'b1;
        case (i_req_type)
            REQ_KEY: begin
                cls.kind = K_KEY;
                keep     = (i_key_index < 6'(KEY_WORDS));
            end
            REQ_FWD: cls.kind = K_FWD;
            REQ_INV: cls.kind = K_INV;
            REQ_ENC: cls.kind = K_ENC;
            REQ_DEC: cls.kind = K_DEC;
            default: keep = 1'b0;
        endcase
    end

    assign busy         = (r_cnt == CW'(DEPTH));
    assign push         = start && !busy && keep;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];
    assign pop          = o_item_valid && i_item_ready;

    // store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end

endmodule

`default_nettype wire

/* design/tarb_back.sv */
// ----------------------------------------------------------------------------
// tarb_back
// Cipher engine: key and table memories, round sequencer, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tarb_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_item_valid,
    input  wire tarb_pkg::t_item i_item,
    output logic                 o_ready,
    output logic                 o_result_valid,
    output logic [63:0]          o_result_word0,
    output logic [63:0]          o_result_word1,
    output logic [63:0]          o_result_word2,
    output logic [63:0]          o_result_word3,
    output logic                 o_was_decrypt
);
    import tarb_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_KREQ = 6'b000010,
        ST_KXOR = 6'b000100,
        ST_TREQ = 6'b001000,
        ST_TADD = 6'b010000,
        ST_MIX  = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_block      r_w, n_w, r_kd, r_tdf, r_tdi, r_out;
    logic        r_dec, n_dec, r_ovalid, n_ovalid, r_odec;
    logic [2:0]  r_round, n_round, r_tbl, n_tbl;
    logic [3:0]  r_kgrp, n_kgrp;

    // four lane copies of each store so all words read in the same cycle
    logic [63:0] r_key_mem [4][KEY_GROUPS];
    logic [63:0] r_fwd_mem [4][TABLE_DEPTH];
    logic [63:0] r_inv_mem [4][TABLE_DEPTH];

    logic        load;
    logic [10:0] waddr;
    logic [10:0] raddr [4];

    assign o_ready = (r_state == ST_IDLE);
    assign load    = o_ready && i_item_valid;
    assign waddr   = {i_item.table_number, i_item.entry_index};

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            raddr[j] = r_dec ? {r_tbl, r_w[j][15:8]} : {r_tbl, r_w[j][7:0]};
        end
    end

    // write loads, read key group and table entries every cycle
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            if (load && i_item.kind == K_KEY && i_item.key_index[1:0] == 2'(j)) begin
                r_key_mem[j][i_item.key_index[5:2]] <= i_item.load_value;
            end
            if (load && i_item.kind == K_FWD) begin
                r_fwd_mem[j][waddr] <= i_item.load_value;
            end
            if (load && i_item.kind == K_INV) begin
                r_inv_mem[j][waddr] <= i_item.load_value;
            end
            r_kd[j]  <= r_key_mem[j][r_kgrp];
            r_tdf[j] <= r_fwd_mem[j][raddr[j]];
            r_tdi[j] <= r_inv_mem[j][raddr[j]];
        end
    end

    // sequence rounds: key XOR, eight table steps, mix, plus a final key XOR; decrypt runs the steps in reverse
    always_comb begin
        n_state  = r_state;
        n_w      = r_w;
        n_dec    = r_dec;
        n_round  = r_round;
        n_tbl    = r_tbl;
        n_kgrp   = r_kgrp;
        n_ovalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid && (i_item.kind == K_ENC || i_item.kind == K_DEC)) begin
                    n_w     = i_item.words;
                    n_dec   = (i_item.kind == K_DEC);
                    n_round = (i_item.kind == K_DEC) ? 3'd7 : 3'd0;
                    n_kgrp  = (i_item.kind == K_DEC) ? KEY_LAST : 4'd0;
                    n_state = ST_KREQ;
                end
            end
            ST_KREQ: n_state = ST_KXOR;
            ST_KXOR: begin
                for (int j = 0; j < 4; j++) begin
                    n_w[j] = r_w[j] ^ r_kd[j];
                end
                if (!r_dec) begin
                    if (r_kgrp == KEY_LAST) begin
                        n_ovalid = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_tbl   = 3'd0;
                        n_state = ST_TREQ;
                    end
                end else if (r_kgrp == KEY_LAST) begin
                    n_tbl   = 3'd7;
                    n_state = ST_TREQ;
                end else if (r_round == 3'd0) begin
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_MIX;
                end
            end
            ST_TREQ: n_state = ST_TADD;
            ST_TADD: begin
                for (int j = 0; j < 4; j++) begin
                    n_w[j] = r_dec ? rotl64(r_w[j], 56) - r_tdi[j]
                                   : rotl64(r_w[j] + r_tdf[j], 8);
                end
                if (!r_dec) begin
                    if (r_tbl == 3'd7) begin
                        if (r_round == 3'd7) begin
                            n_kgrp  = KEY_LAST;
                            n_state = ST_KREQ;
                        end else begin
                            n_state = ST_MIX;
                        end
                    end else begin
                        n_tbl   = r_tbl + 3'd1;
                        n_state = ST_TREQ;
                    end
                end else if (r_tbl == 3'd0) begin
                    n_kgrp  = {1'b0, r_round};
                    n_state = ST_KREQ;
                end else begin
                    n_tbl   = r_tbl - 3'd1;
                    n_state = ST_TREQ;
                end
            end
            ST_MIX: begin
                if (!r_dec) begin
                    n_w     = mix_fwd(r_w);
                    n_round = r_round + 3'd1;
                    n_kgrp  = {1'b0, r_round} + 4'd1;
                    n_state = ST_KREQ;
                end else begin
                    n_w     = mix_inv(r_w);
                    n_round = r_round - 3'd1;
                    n_tbl   = 3'd7;
                    n_state = ST_TREQ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // hold datapath and result registers
    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_dec   <= n_dec;
        r_round <= n_round;
        r_tbl   <= n_tbl;
        r_kgrp  <= n_kgrp;
        if (n_ovalid) begin
            r_out  <= n_w;
            r_odec <= r_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_result_valid = r_ovalid;
    assign o_result_word0 = r_out[0];
    assign o_result_word1 = r_out[1];
    assign o_result_word2 = r_out[2];
    assign o_result_word3 = r_out[3];
    assign o_was_decrypt  = r_odec;

endmodule

`default_nettype wire

/* design/table_add_rotate_block_cipher_256_core.sv */
// ----------------------------------------------------------------------------
// table_add_rotate_block_cipher_256_core
// 256-bit table add-rotate block cipher with key and table load requests.
// ----------------------------------------------------------------------------
// Usage:
//   A beat is taken on a rising edge with start high and busy low. Request
//   codes: load key word, load forward or inverse table entry, encrypt,
//   decrypt. Loads and unknown codes give no result.
//   Beats enter a two-entry queue; busy rises only while it is full.
//   Each result appears for one cycle with o_result_valid high; the
//   receiver cannot stall, so results are never held off.
//   A load is written while the engine idles. A block runs nine key XORs,
//   each a registered key read, then the XOR; 64 table steps, each a
//   registered table read, then add and rotate; and seven mixes. The
//   result is registered from the last key XOR; the engine takes a new
//   block only once that result is out.
//   The next beat is queued while a block is at work.
//   Reset clears the queue and the sequencer; key words and table
//   entries stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module table_add_rotate_block_cipher_256_core #(
    parameter int QUEUE_DEPTH = tarb_pkg::Q_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [5:0]  i_key_index,
    input  wire logic [2:0]  i_table_number,
    input  wire logic [7:0]  i_entry_index,
    input  wire logic [63:0] i_load_value,
    input  wire logic [63:0] i_block_word0,
    input  wire logic [63:0] i_block_word1,
    input  wire logic [63:0] i_block_word2,
    input  wire logic [63:0] i_block_word3,
    output logic             o_result_valid,
    output logic [63:0]      o_result_word0,
    output logic [63:0]      o_result_word1,
    output logic [63:0]      o_result_word2,
    output logic [63:0]      o_result_word3,
    output logic             o_was_decrypt
);
    import tarb_pkg::*;

    t_block words;
    t_item  q_item;
    logic   q_valid, b_ready;

    assign words = {i_block_word3, i_block_word2, i_block_word1, i_block_word0};

    tarb_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_key_index    (i_key_index),
        .i_table_number (i_table_number),
        .i_entry_index  (i_entry_index),
        .i_load_value   (i_load_value),
        .i_words        (words),
        .o_item_valid   (q_valid),
        .o_item         (q_item),
        .i_item_ready   (b_ready)
    );

    tarb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (q_valid),
        .i_item         (q_item),
        .o_ready        (b_ready),
        .o_result_valid (o_result_valid),
        .o_result_word0 (o_result_word0),
        .o_result_word1 (o_result_word1),
        .o_result_word2 (o_result_word2),
        .o_result_word3 (o_result_word3),
        .o_was_decrypt  (o_was_decrypt)
    );

    // a result strobe is never held high
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

    // a result comes only out of a busy engine
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(!b_ready))
        else $error("result without engine work");

    // a full queue always offers an item to the engine
    a_busy_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> q_valid)
        else $error("busy with an empty queue");

endmodule

`default_nettype wire

/* test/tb_table_add_rotate_block_cipher_256_core.sv */
// ----------------------------------------------------------------------------
// tb_table_add_rotate_block_cipher_256_core
// Self-checking bench: loads keys and tables, then checks directed and random
// encrypt and decrypt beats against an in-bench predictor of the cipher.
// ----------------------------------------------------------------------------
module tb_table_add_rotate_block_cipher_256_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tarb_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef logic [63:0] t_word;
    typedef struct {
        t_word w0, w1, w2, w3;
        logic  dec;
    } t_cipher_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_req_type = '0;
    logic [5:0] i_key_index = '0;
    logic [2:0] i_table_number = '0;
    logic [7:0] i_entry_index = '0;
    logic [63:0] i_load_value = '0;
    logic [63:0] i_block_word0 = '0, i_block_word1 = '0;
    logic [63:0] i_block_word2 = '0, i_block_word3 = '0;
    logic o_result_valid;
    logic [63:0] o_result_word0, o_result_word1, o_result_word2, o_result_word3;
    logic o_was_decrypt;

    t_word key_mem [KEY_WORDS];
    t_word fwd_mem [TABLE_DEPTH];
    t_word inv_mem [TABLE_DEPTH];

    t_cipher_out pending_blocks[$];
    int errors = 0;
    int n_enc = 0, n_dec = 0, n_load = 0, n_ign = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    table_add_rotate_block_cipher_256_core u_top (.*);

    function automatic t_word rot(t_word x, int n);
        if (n == 0) return x;
        return (x << n) | (x >> (64 - n));
    endfunction

    // Forward and inverse linear mix, four words held in an array
    function automatic void fwd_mix(ref t_word w[4]);
        w[0] ^= rot(w[1], 11) ^ rot(w[2], 27) ^ rot(w[3], 43);
        w[1] ^= rot(w[0], 24);
        w[2] ^= rot(w[0], 18);
        w[3] ^= rot(w[0], 10);
    endfunction

    function automatic void inv_mix(ref t_word w[4]);
        w[1] ^= rot(w[0], 24);
        w[2] ^= rot(w[0], 18);
        w[3] ^= rot(w[0], 10);
        w[0] ^= rot(w[1], 11) ^ rot(w[2], 27) ^ rot(w[3], 43);
    endfunction

    function automatic t_cipher_out cipher_block(logic dec, t_word b0, t_word b1,
                                                 t_word b2, t_word b3);
        t_word w[4];
        t_word x;
        t_cipher_out r;
        w[0] = b0; w[1] = b1; w[2] = b2; w[3] = b3;
        if (!dec) begin
            for (int rd = 0; rd < 8; rd++) begin
                for (int j = 0; j < 4; j++) w[j] ^= key_mem[4*rd+j];
                for (int t = 0; t < 8; t++)
                    for (int j = 0; j < 4; j++) begin
                        x = w[j] + fwd_mem[t*256 + w[j][7:0]];
                        w[j] = rot(x, 8);
                    end
                if (rd < 7) fwd_mix(w);
            end
            for (int j = 0; j < 4; j++) w[j] ^= key_mem[32+j];
        end else begin
            for (int j = 0; j < 4; j++) w[j] ^= key_mem[32+j];
            for (int rd = 7; rd >= 0; rd--) begin
                for (int t = 7; t >= 0; t--)
                    for (int j = 0; j < 4; j++) begin
                        x = rot(w[j], 56);
                        w[j] = x - inv_mem[t*256 + x[7:0]];
                    end
                for (int j = 0; j < 4; j++) w[j] ^= key_mem[4*rd+j];
                if (rd > 0) inv_mix(w);
            end
        end
        r.w0 = w[0]; r.w1 = w[1]; r.w2 = w[2]; r.w3 = w[3]; r.dec = dec;
        return r;
    endfunction

    // Send one beat and update the predictor on acceptance
    task automatic send_beat(logic [2:0] rt, logic [5:0] ki, logic [2:0] tn,
                             logic [7:0] ei, t_word lv, t_word b0, t_word b1,
                             t_word b2, t_word b3);
        i_req_type <= rt; i_key_index <= ki; i_table_number <= tn;
        i_entry_index <= ei; i_load_value <= lv;
        i_block_word0 <= b0; i_block_word1 <= b1;
        i_block_word2 <= b2; i_block_word3 <= b3;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (rt)
            REQ_KEY: begin
                if (ki < KEY_WORDS) begin
                    key_mem[ki] = lv;
                end
                n_load++;
            end
            REQ_FWD: begin fwd_mem[tn*256+ei] = lv; n_load++; end
            REQ_INV: begin inv_mem[tn*256+ei] = lv; n_load++; end
            REQ_ENC: begin pending_blocks.push_back(cipher_block(0, b0, b1, b2, b3)); n_enc++; end
            REQ_DEC: begin pending_blocks.push_back(cipher_block(1, b0, b1, b2, b3)); n_dec++; end
            default: n_ign++;
        endcase
    endtask

    // Drop start with random gap
    task automatic sender_gap(int max_gap);
        int g;
        g = $urandom_range(0, 3) == 0 ? $urandom_range(1, max_gap) : 0;
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic idle_line();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_empty();
        start <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_word rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_word edge_word(int k);
        case (k % 4)
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0001;
            default: return rnd64();
        endcase
    endfunction

    // Fill every key word and table entry so no read hits an unwritten entry
    task automatic test_fill_state();
        for (int k = 0; k < KEY_WORDS; k++) begin
            send_beat(REQ_KEY, k[5:0], 0, 0, edge_word(k), 0, 0, 0, 0);
            sender_gap(4);
        end
        for (int e = 0; e < TABLE_DEPTH; e++) begin
            send_beat(REQ_FWD, 0, e[10:8], e[7:0], edge_word(e), 0, 0, 0, 0);
            send_beat(REQ_INV, 0, e[10:8], e[7:0], edge_word(e+1), 0, 0, 0, 0);
            sender_gap(3);
        end
    endtask

    // Extremes, both directions, ignored codes and out-of-range key index
    task automatic test_directed();
        send_beat(REQ_ENC, 0, 0, 0, 0, '0, '0, '0, '0);
        send_beat(REQ_DEC, 0, 0, 0, 0, '0, '0, '0, '0);
        send_beat(REQ_ENC, 0, 0, 0, 0, '1, '1, '1, '1);
        send_beat(REQ_DEC, 0, 0, 0, 0, '1, '1, '1, '1);
        send_beat(3'd5, 6'h3f, 3'd7, 8'hff, '1, '1, '1, '1, '1);
        send_beat(3'd6, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(REQ_KEY, 6'd36, 0, 0, '1, 0, 0, 0, 0);
        send_beat(REQ_KEY, 6'd63, 0, 0, '1, 0, 0, 0, 0);
        send_beat(REQ_ENC, 0, 0, 0, 0, 64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0000,
                  64'h1, 64'hfedc_ba98_7654_3210);
        send_beat(REQ_DEC, 0, 0, 0, 0, 64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0000,
                  64'h1, 64'hfedc_ba98_7654_3210);
        send_beat(REQ_KEY, 6'd35, 0, 0, '1, 0, 0, 0, 0);
        send_beat(REQ_FWD, 0, 3'd7, 8'hff, '1, 0, 0, 0, 0);
        send_beat(REQ_INV, 0, 3'd7, 8'hff, '0, 0, 0, 0, 0);
        send_beat(REQ_ENC, 0, 0, 0, 0, rnd64(), rnd64(), rnd64(), rnd64());
        wait_empty();
    endtask

    // Random mix of blocks, loads and noise, sent in bursts
    task automatic test_random(int count);
        int sel, burst;
        logic [2:0] rt;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) rt = REQ_ENC;
            else if (sel < 70) rt = REQ_DEC;
            else if (sel < 77) rt = REQ_KEY;
            else if (sel < 86) rt = REQ_FWD;
            else if (sel < 95) rt = REQ_INV;
            else rt = 3'($urandom_range(5, 7));
            send_beat(rt, (rt == REQ_KEY) ? 6'($urandom_range(0, 40)) : 6'($urandom),
                      3'($urandom), 8'($urandom), rnd64(),
                      rnd64(), rnd64(), rnd64(), rnd64());
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                sender_gap(300);
            end else burst--;
            if (n == count / 2) wait_empty();
        end
        wait_empty();
    endtask

    // Check each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        t_cipher_out e;
        if (i_rst_n && o_result_valid) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected result %h %h %h %h dec=%b", $time,
                         o_result_word0, o_result_word1, o_result_word2,
                         o_result_word3, o_was_decrypt);
                errors++;
            end else begin
                e = pending_blocks.pop_front();
                if ({o_result_word0, o_result_word1, o_result_word2, o_result_word3,
                     o_was_decrypt} !== {e.w0, e.w1, e.w2, e.w3, e.dec}) begin
                    $display("%0t: mismatch expected %h %h %h %h dec=%b", $time,
                             e.w0, e.w1, e.w2, e.w3, e.dec);
                    $display("%0t:          actual   %h %h %h %h dec=%b", $time,
                             o_result_word0, o_result_word1, o_result_word2,
                             o_result_word3, o_was_decrypt);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted and no result
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_result_valid)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_state();
        test_directed();
        test_random(1000);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d encrypts, %0d decrypts, %0d loads, %0d ignored beats.",
                 n_enc, n_dec, n_load, n_ign);
        if (errors == 0 && pending_blocks.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
